@@ rtl/core/sfq_pkg.sv @@
// Shared types and constants for the sortable FIFO queue.
// Depends on nothing; every other file of the block uses it.
package sfq_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Operation codes carried by a request
    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_SORT    = 2'd2
    } op_e_t;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_e_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SORT_LOAD,
        ST_SORT_CMP,
        ST_SORT_STORE
    } state_e_t;

    // Read address source for the entry store
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_J,
        RD_J_NEXT,
        RD_I_NEXT
    } rd_sel_e_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic      enq_wr;
        logic      deq_pop;
        logic      sort_init;
        logic      li_load;
        logic      cmp_step;
        logic      wi_step;
        rd_sel_e_t rd_sel;
        logic      load_res;
        status_e_t res_status;
        logic      res_take_mem;
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic below_two;
        logic j_more;
        logic i_more;
    } dp_status_t;

endpackage

@@ rtl/core/sfq_ifs.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on sfq_pkg for field widths.
interface sfq_in_if;
    logic                                valid;
    logic                                ready;
    logic [sfq_pkg::OP_W-1:0]            op;
    logic signed [sfq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface sfq_out_if;
    logic                                valid;
    logic                                ready;
    logic [sfq_pkg::STAT_W-1:0]          status;
    logic signed [sfq_pkg::DATA_W-1:0]   removed_value;
    logic [sfq_pkg::OCC_W-1:0]           occupancy;

    modport source (output valid, output status, output removed_value, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input occupancy,
                    output ready);
endinterface

@@ rtl/core/sfq_dp.sv @@
// Datapath: circular entry store, head/count, sort indices and result register.
// Depends on sfq_pkg; driven by sfq_ctrl through ctrl_cmd_t.
module sfq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sfq_pkg::ctrl_cmd_t                cmd,
    input  logic signed [sfq_pkg::DATA_W-1:0] value,
    output sfq_pkg::dp_status_t               stat,
    output logic [sfq_pkg::STAT_W-1:0]        res_status,
    output logic signed [sfq_pkg::DATA_W-1:0] res_removed,
    output logic [sfq_pkg::OCC_W-1:0]         res_occupancy
);
    import sfq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W:0]           j_plus1, i_plus1, i_plus2;
    logic                     swap;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr, rd_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [STAT_W-1:0]        out_status_reg;
    logic signed [DATA_W-1:0] out_removed_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    // Physical slot of logical position k; sum stays below twice the depth
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W:0]   k);
        logic [CNT_W+1:0] sum;
        sum = (CNT_W+2)'(base) + (CNT_W+2)'(k);
        if (sum >= (CNT_W+2)'(CAPACITY))
        begin
            sum = sum - (CNT_W+2)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign j_plus1 = (CNT_W+1)'(j_reg) + 1'b1;
    assign i_plus1 = (CNT_W+1)'(i_reg) + 1'b1;
    assign i_plus2 = (CNT_W+1)'(i_reg) + 2'd2;
    assign swap    = cur_reg > rd_data_reg;

    // Status toward the controller
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(CAPACITY));
    assign stat.below_two = (count_reg < CNT_W'(2));
    assign stat.j_more    = (j_plus1 < (CNT_W+1)'(count_reg));
    assign stat.i_more    = (i_plus2 < (CNT_W+1)'(count_reg));

    // Next-state of head, count and sort registers
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cur_next   = cur_reg;
        if (cmd.enq_wr)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.deq_pop)
        begin
            count_next = count_reg - 1'b1;
            head_next  = slot_of(head_reg, (CNT_W+1)'(1));
        end
        if (cmd.sort_init)
        begin
            i_next = '0;
            j_next = CNT_W'(1);
        end
        if (cmd.li_load)
        begin
            cur_next = rd_data_reg;
        end
        if (cmd.cmp_step)
        begin
            if (swap)
            begin
                cur_next = rd_data_reg;
            end
            j_next = j_plus1[CNT_W-1:0];
        end
        if (cmd.wi_step)
        begin
            i_next = i_plus1[CNT_W-1:0];
            j_next = i_plus2[CNT_W-1:0];
        end
    end

    // Store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, (CNT_W+1)'(count_reg));
        wr_data = value;
        if (cmd.cmp_step && swap)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_reg, (CNT_W+1)'(j_reg));
            wr_data = cur_reg;
        end
        else if (cmd.wi_step)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_reg, (CNT_W+1)'(i_reg));
            wr_data = cur_reg;
        end
        else if (cmd.enq_wr)
        begin
            wr_en = 1'b1;
        end
    end

    // Store read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD:   rd_addr = head_reg;
            RD_J:      rd_addr = slot_of(head_reg, (CNT_W+1)'(j_reg));
            RD_J_NEXT: rd_addr = slot_of(head_reg, j_plus1);
            RD_I_NEXT: rd_addr = slot_of(head_reg, i_plus1);
            default:   rd_addr = head_reg;
        endcase
    end

    // Entry store with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Sort working registers and result payload
    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        cur_reg <= cur_next;
        if (cmd.load_res)
        begin
            out_status_reg  <= cmd.res_status;
            out_removed_reg <= cmd.res_take_mem ? rd_data_reg : '0;
            out_occ_reg     <= OCC_W'(count_next);
        end
    end

    assign res_status    = out_status_reg;
    assign res_removed   = out_removed_reg;
    assign res_occupancy = out_occ_reg;

endmodule

@@ rtl/core/sfq_ctrl.sv @@
// Controller: request/result handshake and the sequencer for dequeue and sort.
// Depends on sfq_pkg; commands sfq_dp.
module sfq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sfq_pkg::OP_W-1:0]   op,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    input  sfq_pkg::dp_status_t        stat,
    output sfq_pkg::ctrl_cmd_t         cmd
);
    import sfq_pkg::*;

    state_e_t state_reg, state_next;
    logic     out_valid_reg, out_valid_next;
    logic     accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cmd.enq_wr       = 1'b0;
        cmd.deq_pop      = 1'b0;
        cmd.sort_init    = 1'b0;
        cmd.li_load      = 1'b0;
        cmd.cmp_step     = 1'b0;
        cmd.wi_step      = 1'b0;
        cmd.rd_sel       = RD_HEAD;
        cmd.load_res     = 1'b0;
        cmd.res_status   = STAT_OK;
        cmd.res_take_mem = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_e_t'(op))
                        OP_ENQUEUE:
                        begin
                            cmd.load_res = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.enq_wr = 1'b1;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_res   = 1'b1;
                                cmd.res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                // front entry is being read from the head slot
                                cmd.deq_pop = 1'b1;
                                state_next  = ST_DEQ;
                            end
                        end
                        OP_SORT:
                        begin
                            if (stat.below_two)
                            begin
                                cmd.load_res = 1'b1;
                            end
                            else
                            begin
                                cmd.sort_init = 1'b1;
                                state_next    = ST_SORT_LOAD;
                            end
                        end
                        default:
                        begin
                            cmd.load_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                cmd.load_res     = 1'b1;
                cmd.res_take_mem = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_SORT_LOAD:
            begin
                // take entry i as the running minimum, fetch entry j
                cmd.li_load = 1'b1;
                cmd.rd_sel  = RD_J;
                state_next  = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                // compare/exchange with entry j while fetching j+1
                cmd.cmp_step = 1'b1;
                if (stat.j_more)
                begin
                    cmd.rd_sel = RD_J_NEXT;
                end
                else
                begin
                    state_next = ST_SORT_STORE;
                end
            end
            ST_SORT_STORE:
            begin
                // write back position i, fetch position i+1
                cmd.wi_step = 1'b1;
                cmd.rd_sel  = RD_I_NEXT;
                if (stat.i_more)
                begin
                    state_next = ST_SORT_LOAD;
                end
                else
                begin
                    cmd.load_res = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid
    always_comb
    begin
        if (cmd.load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

@@ rtl/core/sortable_fifo_queue.sv @@
// Sortable FIFO queue of signed 32-bit values (enqueue, dequeue, in-place sort).
// Enqueue, refused and no-op requests load the result from ST_IDLE; a dequeue loads it
//   in ST_DEQ from the registered store read; sorts do one compare-exchange per cycle.
// Enqueue takes 1 request/cycle while results are taken; dequeue/sort block new ones.
// Reset clears head, count and handshake state; store contents stay undefined.
module sortable_fifo_queue #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sfq_in_if.sink     request,
    sfq_out_if.source  result
);
    import sfq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    sfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .op        (request.op),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (request.value),
        .stat          (stat),
        .res_status    (result.status),
        .res_removed   (result.removed_value),
        .res_occupancy (result.occupancy)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sortable_fifo_queue: directed corner requests, then random traffic.
// Depends on sfq_pkg and the sfq_in_if / sfq_out_if channel interfaces.
module tb;
    import sfq_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_RANDOM   = 1950;
    localparam int HOLD_CYCLES  = 300;
    // Longest single request is a sort of a full queue
    localparam int DRAIN_CYCLES = 200;
    // Worst case ~2000 requests, each a full sort plus receiver stall and sender gap, times several
    localparam longint TIME_LIMIT_NS = 64'd25_000_000;
    localparam int MAX_PRINTED  = 60;

    // Queue predictor plus the list of outcomes still owed by the block
    class queue_scoreboard;
        typedef struct packed {
            status_e_t                status;
            logic signed [DATA_W-1:0] removed;
            logic [OCC_W-1:0]         occupancy;
        } outcome_t;

        logic signed [DATA_W-1:0] slots [SLOTS];
        int unsigned              head_pos;
        int unsigned              fill;
        outcome_t                 awaited [$];
        int errors, checked;
        int n_enq, n_deq, n_sort, n_unused, n_full, n_empty, deepest_sort;

        function new();
            head_pos = 0;
            fill     = 0;
            errors   = 0;
            checked  = 0;
            n_enq = 0; n_deq = 0; n_sort = 0; n_unused = 0;
            n_full = 0; n_empty = 0; deepest_sort = 0;
        endfunction

        // Apply one accepted request to the predicted queue
        function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
            outcome_t                 o;
            logic signed [DATA_W-1:0] tmp;
            int unsigned              i, j, si, sj;
            o.status  = STAT_OK;
            o.removed = '0;
            case (op)
                OP_ENQUEUE:
                begin
                    n_enq++;
                    if (fill >= SLOTS)
                    begin
                        o.status = STAT_FULL;
                        n_full++;
                    end
                    else
                    begin
                        slots[(head_pos + fill) % SLOTS] = value;
                        fill++;
                    end
                end
                OP_DEQUEUE:
                begin
                    n_deq++;
                    if (fill == 0)
                    begin
                        o.status = STAT_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        o.removed = slots[head_pos];
                        head_pos  = (head_pos + 1) % SLOTS;
                        fill--;
                    end
                end
                OP_SORT:
                begin
                    n_sort++;
                    if (fill > deepest_sort)
                        deepest_sort = fill;
                    // exchange sort: each position against every later one, signed
                    for (i = 0; i + 1 < fill; i++)
                    begin
                        for (j = i + 1; j < fill; j++)
                        begin
                            si = (head_pos + i) % SLOTS;
                            sj = (head_pos + j) % SLOTS;
                            if (slots[si] > slots[sj])
                            begin
                                tmp       = slots[si];
                                slots[si] = slots[sj];
                                slots[sj] = tmp;
                            end
                        end
                    end
                end
                default:
                    n_unused++;
            endcase
            o.occupancy = OCC_W'(fill);
            awaited.push_back(o);
        endfunction

        task report_mismatch(string what);
            errors++;
            // keep the log short when something breaks badly
            if (errors <= MAX_PRINTED)
                $display("[%0t] ERROR result %0d: %s", $time, checked, what);
        endtask

        // Compare one delivered result with the oldest outstanding outcome
        task check_result(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] removed,
                          logic [OCC_W-1:0] occupancy);
            outcome_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status %0d removed %0d occ %0d",
                                          status, removed, occupancy));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", status, want.status));
            if (removed !== want.removed)
                report_mismatch($sformatf("removed_value got %0d want %0d",
                                          removed, want.removed));
            if (occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy got %0d want %0d",
                                          occupancy, want.occupancy));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sfq_in_if  req_ch ();
    sfq_out_if res_ch ();

    sortable_fifo_queue #(.CAPACITY(SLOTS)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch)
    );

    queue_scoreboard sb = new();

    // Sender pacing
    bit valid_up     = 0;
    int burst_left   = 8;
    int no_gap_left  = 0;
    // Receiver pacing
    int hold_asks    = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;
    int rx_phase     = 0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Offer one request and wait for it to be taken; idle between bursts
    task automatic send_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        valid_up = 1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_request(op, value);
        if (no_gap_left > 0)
            no_gap_left--;
        else if (burst_left > 1)
            burst_left--;
        else
        begin
            // gap: drop valid and scramble the payload, which must be ignored
            req_ch.valid <= 1'b0;
            req_ch.op    <= OP_W'($urandom);
            req_ch.value <= $urandom;
            valid_up = 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back
    task automatic wait_drained();
        if (valid_up)
        begin
            req_ch.valid <= 1'b0;
            valid_up = 0;
        end
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = '0;
                    3:       v = -1;
                    default: v = 1;
                endcase
            end
            // narrow range so sorts see many duplicates
            1, 2, 3: v = DATA_W'(int'($urandom_range(0, 16)) - 8);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // mood 0 fills the queue, 1 drains it, 2 is balanced
    function automatic logic [OP_W-1:0] pick_op(int mood);
        int r;
        int enq_lim, deq_lim;
        r = $urandom_range(0, 99);
        case (mood)
            0:       begin enq_lim = 65; deq_lim = 85; end
            1:       begin enq_lim = 25; deq_lim = 85; end
            default: begin enq_lim = 45; deq_lim = 87; end
        endcase
        if (r < enq_lim)
            return OP_ENQUEUE;
        if (r < deq_lim)
            return OP_DEQUEUE;
        if (r < 97)
            return OP_SORT;
        return OP_UNUSED;
    endfunction

    // Receiver: ready follows a changing pattern, with occasional long hold-offs
    always @(posedge clk)
    begin
        logic nxt;
        rx_phase++;
        if (holds_served != hold_asks)
        begin
            holds_served = hold_asks;
            hold_left    = HOLD_CYCLES;
        end
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(64, 512);
        end
        else
            rx_mode_left--;
        case (rx_mode)
            0:       nxt = 1'b1;
            1:       nxt = 1'($urandom_range(0, 1));
            2:       nxt = (rx_phase % 8 == 0);
            default: nxt = (rx_phase % 3 != 0);
        endcase
        if (hold_left > 0)
        begin
            nxt = 1'b0;
            hold_left--;
        end
        res_ch.ready <= nxt;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            sb.check_result(res_ch.status, res_ch.removed_value, res_ch.occupancy);
    end

    // Run limit
    initial
    begin
        #TIME_LIMIT_NS;
        $display("[%0t] timeout with %0d results outstanding", $time, sb.awaited.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main stimulus
    initial
    begin
        int mood;
        int n, k;
        logic signed [DATA_W-1:0] v;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_ENQUEUE;
        req_ch.value = '0;
        res_ch.ready = 1'b0;
        mood         = 2;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue corners
        send_request(OP_DEQUEUE, 32'sh1234_5678);
        send_request(OP_SORT, '0);
        send_request(OP_UNUSED, -1);
        // single entry sort, then extremes sorted
        send_request(OP_ENQUEUE, 32'sh7FFF_FFFF);
        send_request(OP_SORT, '0);
        send_request(OP_ENQUEUE, 32'sh8000_0000);
        send_request(OP_ENQUEUE, '0);
        send_request(OP_ENQUEUE, -1);
        send_request(OP_ENQUEUE, 1);
        send_request(OP_SORT, -1);
        send_request(OP_UNUSED, 32'sh7FFF_FFFF);
        send_request(OP_DEQUEUE, '0);
        // fill to capacity with the head moved off slot zero, so the buffer wraps
        for (k = 0; k < 12; k++)
        begin
            if (k == 0)
                v = 32'shAAAA_AAAA;
            else if (k == 1)
                v = 32'sh5555_5555;
            else
                v = DATA_W'(int'(k % 4) * 5 - 6);
            send_request(OP_ENQUEUE, v);
        end
        send_request(OP_ENQUEUE, 42);
        send_request(OP_SORT, '0);
        send_request(OP_DEQUEUE, '0);

        // Random traffic in phases of different mood
        for (n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % 50 == 0)
                mood = $urandom_range(0, 2);
            if (n == 600)
            begin
                // receiver holds off while requests keep coming back to back
                hold_asks++;
                no_gap_left = 40;
                mood = 0;
            end
            if (n == 1300)
                wait_drained();
            send_request(pick_op(mood), pick_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d enqueue, %0d dequeue, %0d sort, %0d unused op; %0d checked",
                 sb.n_enq + sb.n_deq + sb.n_sort + sb.n_unused, sb.n_enq, sb.n_deq,
                 sb.n_sort, sb.n_unused, sb.checked);
        $display("Refused %0d enqueues when full and %0d dequeues when empty; deepest sort %0d",
                 sb.n_full, sb.n_empty, sb.deepest_sort);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/sfq_pkg.sv
rtl/core/sfq_ifs.sv
rtl/core/sfq_dp.sv
rtl/core/sfq_ctrl.sv
rtl/core/sortable_fifo_queue.sv
tb/tb.sv
